// ----- design/bwbc_pkg.sv -----
package bwbc_pkg;

    localparam int NUM_FACES  = 6;
    localparam int NUM_REGS   = 8;
    localparam int MODE_BITS  = 2;
    localparam int FACE_BITS  = 3;
    localparam int INDEX_BITS = 3;

    typedef enum logic [MODE_BITS-1:0] {
        MODE_REFLECT = 2'd0,
        MODE_ABSORB  = 2'd1,
        MODE_PERM    = 2'd2,
        MODE_NONE    = 2'd3
    } mode_t;

    typedef enum logic [INDEX_BITS-1:0] {
        REG_BOUND_X_LOW  = 3'd0,
        REG_BOUND_X_HIGH = 3'd1,
        REG_BOUND_Y_LOW  = 3'd2,
        REG_BOUND_Y_HIGH = 3'd3,
        REG_BOUND_Z_LOW  = 3'd4,
        REG_BOUND_Z_HIGH = 3'd5,
        REG_WALL_MODES   = 3'd6,
        REG_PERMS        = 3'd7
    } reg_idx_t;

    typedef enum logic {
        REQ_PROCESS = 1'b0,
        REQ_READ    = 1'b1
    } req_t;

    typedef struct packed {
        logic                 valid;
        req_t                 req_type;
        logic                 active;
        logic [FACE_BITS-1:0] face;
        logic [NUM_FACES-1:0] attempt_mask;
        logic [NUM_FACES-1:0] cross_mask;
        logic [NUM_FACES-1:0] absorb_mask;
    } ctl_t;

endpackage

// ----- design/box_wall_boundary_conditions_top.sv -----
// Channel   | Handshake                 | Payload
// ----------+---------------------------+------------------------------------------
// s (in)    | s_tvalid / s_tready       | s_tdata particle, s_tuser request kind
// m (out)   | m_tvalid / m_tready       | m_tdata position, masks, counters
// cfg       | cfg_we                    | cfg_index, cfg_data
//
// One transaction per cycle sustained while s_tready is high; each passes six face cells,
// each a register stage, then an output FIFO.
// Reset empties the cells and FIFO, zeroes the counters and loads the wall defaults.
// s_tready follows a credit count of transactions in flight against the FIFO depth,
// so a stall on m holds nothing in the cells and s keeps flowing until the FIFO fills.
module box_wall_boundary_conditions_top #(
    parameter int POS_WIDTH   = 32,
    parameter int COUNT_WIDTH = 32,
    parameter int ROLL_BITS   = 8,
    localparam int IN_BITS    = 3 * POS_WIDTH + 1 + 6 * ROLL_BITS + 3,
    localparam int IN_W       = ((IN_BITS + 7) / 8) * 8,
    localparam int OUT_BITS   = 3 * POS_WIDTH + 1 + 18 + 3 * COUNT_WIDTH,
    localparam int OUT_W      = ((OUT_BITS + 7) / 8) * 8,
    localparam int PERM_W     = 6 * (ROLL_BITS + 1),
    localparam int CFG_W0     = (POS_WIDTH > 12) ? POS_WIDTH : 12,
    localparam int CFG_W      = (CFG_W0 > PERM_W) ? CFG_W0 : PERM_W
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // pos_x, pos_y, pos_z, active_in, rolls, counter_face, zero pad
    input  logic [IN_W-1:0]                  s_tdata,
    // req_type
    input  logic                             s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // new_x, new_y, new_z, active_out, attempt_mask, cross_mask, absorb_mask,
    // attempts_read, crossings_read, absorbed_read, zero pad
    output logic [OUT_W-1:0]                 m_tdata,
    input  logic                             cfg_we,
    input  logic [bwbc_pkg::INDEX_BITS-1:0]  cfg_index,
    input  logic [CFG_W-1:0]                 cfg_data
);
    import bwbc_pkg::*;

    localparam int FIFO_DEPTH = 16;
    localparam int CRED_W     = $clog2(FIFO_DEPTH + 1);
    localparam int ROLL_W     = 6 * ROLL_BITS;

    logic signed [POS_WIDTH-1:0] bound_reg [NUM_FACES];
    logic [2*NUM_FACES-1:0]      modes_reg;
    logic [PERM_W-1:0]           perm_reg;
    logic [CRED_W-1:0]           credit_reg, credit_next;

    ctl_t                        ctl   [NUM_FACES+1];
    logic signed [POS_WIDTH-1:0] pos_x [NUM_FACES+1];
    logic signed [POS_WIDTH-1:0] pos_y [NUM_FACES+1];
    logic signed [POS_WIDTH-1:0] pos_z [NUM_FACES+1];
    logic [ROLL_W-1:0]           rolls [NUM_FACES+1];
    logic [COUNT_WIDTH-1:0]      att_rd [NUM_FACES+1];
    logic [COUNT_WIDTH-1:0]      crs_rd [NUM_FACES+1];
    logic [COUNT_WIDTH-1:0]      abs_rd [NUM_FACES+1];

    logic                        s_fire;
    logic                        m_fire;
    logic                        is_read;
    logic [OUT_W-1:0]            result;

    assign s_tready = credit_reg < CRED_W'(FIFO_DEPTH);
    assign s_fire   = s_tvalid && s_tready;
    assign m_fire   = m_tvalid && m_tready;
    assign is_read  = s_tuser == REQ_READ;

    always_comb
    begin
        credit_next = credit_reg + CRED_W'(s_fire) - CRED_W'(m_fire);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            credit_reg <= '0;
        end
        else
        begin
            credit_reg <= credit_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int f = 0; f < NUM_FACES; f++)
            begin
                bound_reg[f] <= (f % 2 == 1) ? {1'b0, {(POS_WIDTH-1){1'b1}}}
                                             : {1'b1, {(POS_WIDTH-1){1'b0}}};
            end
            modes_reg <= '0;
            perm_reg  <= '0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_WALL_MODES)
            begin
                modes_reg <= cfg_data[2*NUM_FACES-1:0];
            end
            else if (cfg_index == REG_PERMS)
            begin
                perm_reg <= cfg_data[PERM_W-1:0];
            end
            else
            begin
                bound_reg[cfg_index] <= cfg_data[POS_WIDTH-1:0];
            end
        end
    end

    always_comb
    begin
        ctl[0]              = '0;
        ctl[0].valid        = s_fire;
        ctl[0].req_type     = req_t'(s_tuser);
        ctl[0].active       = is_read ? 1'b0 : s_tdata[3*POS_WIDTH];
        ctl[0].face         = s_tdata[3*POS_WIDTH+1+ROLL_W +: FACE_BITS];
        pos_x[0]            = is_read ? '0 : s_tdata[0 +: POS_WIDTH];
        pos_y[0]            = is_read ? '0 : s_tdata[POS_WIDTH +: POS_WIDTH];
        pos_z[0]            = is_read ? '0 : s_tdata[2*POS_WIDTH +: POS_WIDTH];
        rolls[0]            = s_tdata[3*POS_WIDTH+1 +: ROLL_W];
        att_rd[0]           = '0;
        crs_rd[0]           = '0;
        abs_rd[0]           = '0;
    end

    for (genvar f = 0; f < NUM_FACES; f++)
    begin : g_cell
        bwbc_cell #(
            .FACE        (f),
            .POS_WIDTH   (POS_WIDTH),
            .COUNT_WIDTH (COUNT_WIDTH),
            .ROLL_BITS   (ROLL_BITS)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl_in     (ctl[f]),
            .pos_x_in   (pos_x[f]),
            .pos_y_in   (pos_y[f]),
            .pos_z_in   (pos_z[f]),
            .rolls_in   (rolls[f]),
            .att_rd_in  (att_rd[f]),
            .crs_rd_in  (crs_rd[f]),
            .abs_rd_in  (abs_rd[f]),
            .wall       (bound_reg[f]),
            .mode       (modes_reg[2*f +: 2]),
            .perm       (perm_reg[f*(ROLL_BITS+1) +: ROLL_BITS+1]),
            .ctl_out    (ctl[f+1]),
            .pos_x_out  (pos_x[f+1]),
            .pos_y_out  (pos_y[f+1]),
            .pos_z_out  (pos_z[f+1]),
            .rolls_out  (rolls[f+1]),
            .att_rd_out (att_rd[f+1]),
            .crs_rd_out (crs_rd[f+1]),
            .abs_rd_out (abs_rd[f+1])
        );
    end

    assign result = OUT_W'({abs_rd[NUM_FACES], crs_rd[NUM_FACES], att_rd[NUM_FACES],
                            ctl[NUM_FACES].absorb_mask, ctl[NUM_FACES].cross_mask,
                            ctl[NUM_FACES].attempt_mask, ctl[NUM_FACES].active,
                            pos_z[NUM_FACES], pos_y[NUM_FACES], pos_x[NUM_FACES]});

    bwbc_fifo #(
        .WIDTH (OUT_W),
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (ctl[NUM_FACES].valid),
        .push_data (result),
        .valid     (m_tvalid),
        .pop       (m_tready),
        .head      (m_tdata)
    );

endmodule

// ----- design/bwbc_cell.sv -----
module bwbc_cell #(
    parameter int FACE        = 0,
    parameter int POS_WIDTH   = 32,
    parameter int COUNT_WIDTH = 32,
    parameter int ROLL_BITS   = 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  bwbc_pkg::ctl_t                 ctl_in,
    input  logic signed [POS_WIDTH-1:0]    pos_x_in,
    input  logic signed [POS_WIDTH-1:0]    pos_y_in,
    input  logic signed [POS_WIDTH-1:0]    pos_z_in,
    input  logic [6*ROLL_BITS-1:0]         rolls_in,
    input  logic [COUNT_WIDTH-1:0]         att_rd_in,
    input  logic [COUNT_WIDTH-1:0]         crs_rd_in,
    input  logic [COUNT_WIDTH-1:0]         abs_rd_in,
    input  logic signed [POS_WIDTH-1:0]    wall,
    input  logic [1:0]                     mode,
    input  logic [ROLL_BITS:0]             perm,
    output bwbc_pkg::ctl_t                 ctl_out,
    output logic signed [POS_WIDTH-1:0]    pos_x_out,
    output logic signed [POS_WIDTH-1:0]    pos_y_out,
    output logic signed [POS_WIDTH-1:0]    pos_z_out,
    output logic [6*ROLL_BITS-1:0]         rolls_out,
    output logic [COUNT_WIDTH-1:0]         att_rd_out,
    output logic [COUNT_WIDTH-1:0]         crs_rd_out,
    output logic [COUNT_WIDTH-1:0]         abs_rd_out
);
    import bwbc_pkg::*;

    localparam int  DIM  = FACE / 2;
    localparam bit  HIGH = (FACE % 2) == 1;
    localparam int  EXT  = POS_WIDTH + 2;
    localparam logic [FACE_BITS-1:0] FACE_CODE = FACE_BITS'(FACE);

    ctl_t                           ctl_reg, ctl_next;
    logic signed [POS_WIDTH-1:0]    pos_x_reg, pos_x_next;
    logic signed [POS_WIDTH-1:0]    pos_y_reg, pos_y_next;
    logic signed [POS_WIDTH-1:0]    pos_z_reg, pos_z_next;
    logic [6*ROLL_BITS-1:0]         rolls_reg;
    logic [COUNT_WIDTH-1:0]         att_rd_reg, att_rd_next;
    logic [COUNT_WIDTH-1:0]         crs_rd_reg, crs_rd_next;
    logic [COUNT_WIDTH-1:0]         abs_rd_reg, abs_rd_next;
    logic [COUNT_WIDTH-1:0]         att_cnt_reg, att_cnt_next;
    logic [COUNT_WIDTH-1:0]         crs_cnt_reg, crs_cnt_next;
    logic [COUNT_WIDTH-1:0]         abs_cnt_reg, abs_cnt_next;

    logic signed [POS_WIDTH-1:0]    coord;
    logic signed [POS_WIDTH-1:0]    coord_new;
    logic signed [EXT-1:0]          refl_ext;
    logic signed [EXT-1:0]          max_ext;
    logic signed [EXT-1:0]          min_ext;
    logic signed [POS_WIDTH-1:0]    refl;
    logic [ROLL_BITS-1:0]           roll;
    logic                           over;
    logic                           hit;
    logic                           crosses;
    logic                           is_process;

    always_comb
    begin
        case (DIM)
            0:       coord = pos_x_in;
            1:       coord = pos_y_in;
            default: coord = pos_z_in;
        endcase
        over       = HIGH ? (coord > wall) : (coord < wall);
        is_process = ctl_in.valid && (ctl_in.req_type == REQ_PROCESS);
        hit        = is_process && ctl_in.active && over;
        roll       = rolls_in[FACE*ROLL_BITS +: ROLL_BITS];
        crosses    = {1'b0, roll} < perm;

        max_ext  = EXT'({1'b0, {(POS_WIDTH-1){1'b1}}});
        min_ext  = -max_ext - EXT'(1);
        refl_ext = (EXT'(wall) <<< 1) - EXT'(coord);
        if (refl_ext > max_ext)
        begin
            refl = {1'b0, {(POS_WIDTH-1){1'b1}}};
        end
        else if (refl_ext < min_ext)
        begin
            refl = {1'b1, {(POS_WIDTH-1){1'b0}}};
        end
        else
        begin
            refl = refl_ext[POS_WIDTH-1:0];
        end

        ctl_next     = ctl_in;
        coord_new    = coord;
        att_cnt_next = att_cnt_reg;
        crs_cnt_next = crs_cnt_reg;
        abs_cnt_next = abs_cnt_reg;
        if (hit)
        begin
            case (mode_t'(mode))
                MODE_REFLECT:
                begin
                    coord_new = refl;
                end
                MODE_ABSORB:
                begin
                    coord_new                  = wall;
                    ctl_next.active            = 1'b0;
                    ctl_next.absorb_mask[FACE] = 1'b1;
                    if (abs_cnt_reg != '1)
                    begin
                        abs_cnt_next = abs_cnt_reg + 1'b1;
                    end
                end
                MODE_PERM:
                begin
                    ctl_next.attempt_mask[FACE] = 1'b1;
                    if (att_cnt_reg != '1)
                    begin
                        att_cnt_next = att_cnt_reg + 1'b1;
                    end
                    if (crosses)
                    begin
                        ctl_next.cross_mask[FACE] = 1'b1;
                        if (crs_cnt_reg != '1)
                        begin
                            crs_cnt_next = crs_cnt_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        coord_new = refl;
                    end
                end
                default:
                begin
                    coord_new = coord;
                end
            endcase
        end

        pos_x_next = (DIM == 0) ? coord_new : pos_x_in;
        pos_y_next = (DIM == 1) ? coord_new : pos_y_in;
        pos_z_next = (DIM == 2) ? coord_new : pos_z_in;

        att_rd_next = att_rd_in;
        crs_rd_next = crs_rd_in;
        abs_rd_next = abs_rd_in;
        if (ctl_in.valid && (ctl_in.req_type == REQ_READ) && (ctl_in.face == FACE_CODE))
        begin
            att_rd_next = att_cnt_reg;
            crs_rd_next = crs_cnt_reg;
            abs_rd_next = abs_cnt_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg     <= '0;
            att_cnt_reg <= '0;
            crs_cnt_reg <= '0;
            abs_cnt_reg <= '0;
        end
        else
        begin
            ctl_reg     <= ctl_next;
            att_cnt_reg <= att_cnt_next;
            crs_cnt_reg <= crs_cnt_next;
            abs_cnt_reg <= abs_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_x_reg  <= pos_x_next;
        pos_y_reg  <= pos_y_next;
        pos_z_reg  <= pos_z_next;
        rolls_reg  <= rolls_in;
        att_rd_reg <= att_rd_next;
        crs_rd_reg <= crs_rd_next;
        abs_rd_reg <= abs_rd_next;
    end

    assign ctl_out    = ctl_reg;
    assign pos_x_out  = pos_x_reg;
    assign pos_y_out  = pos_y_reg;
    assign pos_z_out  = pos_z_reg;
    assign rolls_out  = rolls_reg;
    assign att_rd_out = att_rd_reg;
    assign crs_rd_out = crs_rd_reg;
    assign abs_rd_out = abs_rd_reg;

endmodule

// ----- design/bwbc_fifo.sv -----
module bwbc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             valid,
    input  logic             pop,
    output logic [WIDTH-1:0] head
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] head_reg;
    logic             head_valid_reg, head_valid_next;
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             load;
    logic             fetch;
    logic             bypass;
    logic             store;

    always_comb
    begin
        load            = !head_valid_reg || pop;
        fetch           = load && (count_reg != '0);
        bypass          = load && (count_reg == '0) && push;
        store           = push && !bypass;
        head_valid_next = head_valid_reg;
        if (load)
        begin
            head_valid_next = fetch || bypass;
        end
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (store)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (fetch)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + CNT_W'(store) - CNT_W'(fetch);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            count_reg      <= '0;
            head_valid_reg <= 1'b0;
        end
        else
        begin
            wr_ptr_reg     <= wr_ptr_next;
            rd_ptr_reg     <= rd_ptr_next;
            count_reg      <= count_next;
            head_valid_reg <= head_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (store)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
        if (fetch)
        begin
            head_reg <= mem[rd_ptr_reg];
        end
        else if (bypass)
        begin
            head_reg <= push_data;
        end
    end

    assign valid = head_valid_reg;
    assign head  = head_reg;

endmodule

// ----- design/bwbc_checker.sv -----
module bwbc_checker #(
    parameter int POS_WIDTH   = 32,
    parameter int COUNT_WIDTH = 32,
    parameter int OUT_W       = 216
) (
    input logic             clk,
    input logic             rst_n,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [OUT_W-1:0] m_tdata
);

    localparam int ACT = 3 * POS_WIDTH;
    localparam int ATT = ACT + 1;
    localparam int CRS = ATT + 6;
    localparam int ABS = CRS + 6;

    logic       active_out;
    logic [5:0] attempt_mask;
    logic [5:0] cross_mask;
    logic [5:0] absorb_mask;

    assign active_out   = m_tdata[ACT];
    assign attempt_mask = m_tdata[ATT +: 6];
    assign cross_mask   = m_tdata[CRS +: 6];
    assign absorb_mask  = m_tdata[ABS +: 6];

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_cross_needs_attempt: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (cross_mask & ~attempt_mask) == 6'd0)
        else $error("crossing without attempt");

    a_single_absorb: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> $onehot0(absorb_mask) && (absorb_mask & attempt_mask) == 6'd0)
        else $error("absorb mask malformed");

    a_absorb_inactive: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && absorb_mask != 6'd0 |-> !active_out)
        else $error("absorbed particle still active");

endmodule

bind box_wall_boundary_conditions_top bwbc_checker #(
    .POS_WIDTH   (POS_WIDTH),
    .COUNT_WIDTH (COUNT_WIDTH),
    .OUT_W       (OUT_W)
) u_bwbc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
